[rtl/utf8_to_bmp_decoder_assert.svh]
// Assertion macros shared by the UTF-8 decoder RTL.
// Each macro expects clk and rst_n to be in scope in the including module.
`ifndef UTF8_TO_BMP_DECODER_ASSERT_SVH
`define UTF8_TO_BMP_DECODER_ASSERT_SVH

// Check a same-cycle implication outside reset.
`define U8B_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, outside reset.
`define U8B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/u8b_pkg.sv]
// Package for the UTF-8 to 16-bit character decoder.
// Holds the result bundle type, special code words and byte classification.
`timescale 1ns / 1ps

package u8b_pkg;

  // Error word for an illegal or unfinished sequence, replacement above 16 bits
  localparam logic [15:0] ERR_WORD  = 16'hFDFF;
  localparam logic [15:0] REPL_WORD = 16'hFFFD;

  // Kind of the final result in a bundle
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CHAR,
    TAIL_ERR
  } tail_kind_t;

  // All results caused by one input item: err_cnt error words, then the tail
  typedef struct packed {
    logic [1:0]  err_cnt;
    tail_kind_t  tail;
    logic [15:0] code;
    logic        eos;
  } bundle_t;

  // Sequence length called for by a lead byte, 0 for an illegal lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = 3'd1;
    else if (b < 8'hC2) len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF5) len = 3'd4;
    else                len = 3'd0;
    return len;
  endfunction

  // Is b a legal continuation; first marks the byte right after the lead
  function automatic logic follow_ok(input logic [7:0] lead, input logic first,
                                     input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (first) begin
      if (lead == 8'hE0)      lo = 8'hA0;
      else if (lead == 8'hED) hi = 8'h9F;
      else if (lead == 8'hF0) lo = 8'h90;
      else if (lead == 8'hF4) hi = 8'h8F;
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

[rtl/utf8_to_bmp_decoder.sv]
// Top level of the UTF-8 to 16-bit character decoder.
// Depends on u8b_pkg, u8b_decode and u8b_emit.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | data_byte, end_of_string
//   out_    | output    | out_valid / out_stall| char_code, illegal, last_result
//
// An item passes the input register, is decoded combinationally into a bundle of
// up to four results, and the bundle sits in the result register; its first
// result is offered the cycle after the item leaves the input register.
// One byte per cycle is taken while each byte gives at most one result and
// out_stall stays low; a byte that only extends a sequence gives none.
// A byte that breaks a held sequence gives up to held + 1 results, one per
// cycle while out_stall is low; a following byte with a result waits in the
// input register, in_stall high, until the last of them is taken.
// Synchronous active-low reset clears all valid flags and the held count.
`timescale 1ns / 1ps

module utf8_to_bmp_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char_code,
  output logic        out_illegal,
  output logic        out_last_result
);

  logic       iv_r;
  logic [7:0] byte_r;
  logic       eos_r;

  u8b_pkg::bundle_t bundle;
  logic             ob_free;
  logic             has_result;
  logic             fire;
  logic             in_take;

  // Decode fires when the byte gives no result or the result register can take its bundle
  assign has_result = (bundle.err_cnt != 2'd0) || (bundle.tail != u8b_pkg::TAIL_NONE);
  assign fire       = iv_r && (!has_result || ob_free);
  assign in_stall   = iv_r && !fire;
  assign in_take    = in_valid && !in_stall;

  // Input register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_take) begin
      iv_r <= 1'b1;
    end else if (fire) begin
      iv_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_string;
    end
  end

  u8b_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .data_byte (byte_r),
    .eos       (eos_r),
    .bundle    (bundle)
  );

  u8b_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire && has_result),
    .bundle          (bundle),
    .free            (ob_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_illegal     (out_illegal),
    .out_last_result (out_last_result)
  );

endmodule

[rtl/u8b_decode.sv]
// Sequence state and single-pass decode of one byte into a result bundle.
// Depends on u8b_pkg and the assertion macro header.
`timescale 1ns / 1ps

module u8b_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [7:0]       data_byte,
  input  logic             eos,
  output u8b_pkg::bundle_t bundle
);

  `include "utf8_to_bmp_decoder_assert.svh"

  // Held partial sequence: count, lead byte, total length, gathered bits
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  need_r, need_nxt;
  logic [14:0] acc_r, acc_nxt;

  logic        cont_ok;
  logic        complete;
  logic [2:0]  blen;
  logic [20:0] code21;
  logic [7:0]  lead_mask;

  assign blen     = u8b_pkg::lead_len(data_byte);
  assign cont_ok  = (cnt_r != 2'd0) &&
                    u8b_pkg::follow_ok(lead_r, cnt_r == 2'd1, data_byte);
  assign complete = (({1'b0, cnt_r} + 3'd1) == need_r);
  assign code21   = {acc_r, data_byte[5:0]};

  // Payload bits kept from a fresh lead
  always_comb begin
    case (blen)
      3'd2:    lead_mask = 8'h1F;
      3'd3:    lead_mask = 8'h0F;
      default: lead_mask = 8'h07;
    endcase
  end

  // Decode the byte against the held sequence
  always_comb begin
    cnt_nxt        = cnt_r;
    lead_nxt       = lead_r;
    need_nxt       = need_r;
    acc_nxt        = acc_r;
    bundle.err_cnt = 2'd0;
    bundle.tail    = u8b_pkg::TAIL_NONE;
    bundle.code    = u8b_pkg::ERR_WORD;
    bundle.eos     = eos;
    if (cont_ok && complete) begin
      // finish the sequence
      bundle.tail = u8b_pkg::TAIL_CHAR;
      bundle.code = (code21[20:16] != 5'd0) ? u8b_pkg::REPL_WORD : code21[15:0];
      cnt_nxt     = 2'd0;
    end else if (cont_ok && !eos) begin
      // extend the sequence, no result yet
      cnt_nxt = cnt_r + 2'd1;
      acc_nxt = {acc_r[8:0], data_byte[5:0]};
    end else begin
      // flush every held byte as an error, then treat the byte as a lead
      bundle.err_cnt = cnt_r;
      cnt_nxt        = 2'd0;
      if (blen == 3'd1) begin
        bundle.tail = u8b_pkg::TAIL_CHAR;
        bundle.code = {8'h00, data_byte};
      end else if (blen == 3'd0 || eos) begin
        bundle.tail = u8b_pkg::TAIL_ERR;
      end else begin
        cnt_nxt  = 2'd1;
        lead_nxt = data_byte;
        need_nxt = blen;
        acc_nxt  = {7'd0, data_byte & lead_mask};
      end
    end
  end

  // Advance the held count on each decoded item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Hold the sequence payload
  always_ff @(posedge clk) begin
    if (load) begin
      lead_r <= lead_nxt;
      need_r <= need_nxt;
      acc_r  <= acc_nxt;
    end
  end

  `U8B_ASSERT_NOW(a_held_fits, cnt_r != 2'd0, (need_r > {1'b0, cnt_r}) && (need_r >= 3'd2), "held count exceeds sequence length")
  `U8B_ASSERT_NEXT(a_eos_clears, load && eos, cnt_r == 2'd0, "bytes held after end of string")

endmodule

[rtl/u8b_emit.sv]
// Result register and sequencer that hands out a bundle one result at a time.
// Depends on u8b_pkg and the assertion macro header.
`timescale 1ns / 1ps

module u8b_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  u8b_pkg::bundle_t bundle,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      out_char_code,
  output logic             out_illegal,
  output logic             out_last_result
);

  `include "utf8_to_bmp_decoder_assert.svh"

  logic             ob_valid_r;
  u8b_pkg::bundle_t ob_r;
  logic [1:0]       idx_r;

  logic [2:0] total;
  logic       last;
  logic       in_err;
  logic       take;

  // Count the results held and spot the final one
  assign total  = {1'b0, ob_r.err_cnt} + ((ob_r.tail != u8b_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
  assign last   = (({1'b0, idx_r} + 3'd1) == total);
  assign in_err = (idx_r < ob_r.err_cnt);
  assign take   = ob_valid_r && !out_stall;
  assign free   = !ob_valid_r || (take && last);

  // Drive the current result
  assign out_valid       = ob_valid_r;
  assign out_char_code   = in_err ? u8b_pkg::ERR_WORD : ob_r.code;
  assign out_illegal     = in_err || (ob_r.tail == u8b_pkg::TAIL_ERR);
  assign out_last_result = ob_r.eos && last;

  // Load a bundle, step through it, drop it after its last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      idx_r      <= 2'd0;
    end else if (load) begin
      ob_valid_r <= 1'b1;
      idx_r      <= 2'd0;
    end else if (take && last) begin
      ob_valid_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // Hold the bundle payload
  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= bundle;
    end
  end

  `U8B_ASSERT_NOW(a_nonempty, ob_valid_r, total != 3'd0, "empty bundle in result register")
  `U8B_ASSERT_NEXT(a_more_follow, take && !last, out_valid, "bundle dropped before its last result")

endmodule

[sim/utf8_to_bmp_decoder_test.sv]
// Self-checking testbench for utf8_to_bmp_decoder: UTF-8 bytes in, 16-bit characters out.
// Depends on u8b_pkg for the error and replacement words; it runs on its own
// decoder of the byte stream.
`timescale 1ns / 1ps

module utf8_to_bmp_decoder_test;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 150;

  // One decoded character as it leaves the block
  typedef struct packed {
    logic [15:0] char_code;
    logic        illegal;
    logic        last_result;
  } bmp_char_t;

  // Decodes every accepted byte on its own and matches the block's characters
  class utf8_char_tracker;
    logic [7:0]  held_bytes [3];
    int unsigned held_count;
    bmp_char_t   pending_chars [$];
    int unsigned mismatch_count;

    function new();
      held_bytes = '{8'h00, 8'h00, 8'h00};
      held_count = 0;
      mismatch_count = 0;
    endfunction

    // Length a lead byte asks for; zero marks a byte that cannot lead
    function int unsigned lead_span(logic [7:0] b);
      if (b < 8'h80) return 1;
      if (b < 8'hC2) return 0;
      if (b < 8'hE0) return 2;
      if (b < 8'hF0) return 3;
      if (b < 8'hF5) return 4;
      return 0;
    endfunction

    // Continuation range, narrowed for the byte right after some leads
    function bit cont_fits(logic [7:0] lead, bit right_after, logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (right_after) begin
        case (lead)
          8'hE0: lo = 8'hA0;
          8'hED: hi = 8'h9F;
          8'hF0: lo = 8'h90;
          8'hF4: hi = 8'h8F;
          default: ;
        endcase
      end
      return (b >= lo) && (b <= hi);
    endfunction

    function int unsigned pending_count();
      return pending_chars.size();
    endfunction

    // Add one accepted byte and queue every character it completes
    function void take_byte(logic [7:0] data_byte, logic eos);
      logic [7:0]  pend [4];
      bmp_char_t   fresh [4];
      int unsigned n;
      int unsigned first;
      int unsigned want;
      int unsigned avail;
      int unsigned k;
      int unsigned made;
      bit          bad;
      logic [20:0] cp;
      for (k = 0; k < 3; k++) pend[k] = held_bytes[k];
      pend[3] = 8'h00;
      n = held_count;
      pend[n] = data_byte;
      n++;
      first = 0;
      made = 0;
      while (first < n) begin
        want = lead_span(pend[first]);
        avail = n - first;
        bad = (want == 0);
        for (k = 1; !bad && k < want && k < avail; k++)
          if (!cont_fits(pend[first], k == 1, pend[first + k])) bad = 1'b1;
        // hold a legal but unfinished sequence until more bytes come
        if (!bad && avail < want && !eos) break;
        if (bad || avail < want) begin
          fresh[made].char_code = u8b_pkg::ERR_WORD;
          fresh[made].illegal = 1'b1;
          first++;
        end else begin
          case (want)
            1: cp = {13'd0, pend[first]};
            2: cp = {16'd0, pend[first][4:0]};
            3: cp = {17'd0, pend[first][3:0]};
            default: cp = {18'd0, pend[first][2:0]};
          endcase
          for (k = 1; k < want; k++) cp = {cp[14:0], pend[first + k][5:0]};
          fresh[made].char_code = (cp > 21'h00FFFF) ? u8b_pkg::REPL_WORD : cp[15:0];
          fresh[made].illegal = 1'b0;
          first += want;
        end
        fresh[made].last_result = 1'b0;
        made++;
      end
      if (eos && made > 0) fresh[made - 1].last_result = 1'b1;
      for (k = 0; k < made; k++) pending_chars.push_back(fresh[k]);
      // keep whatever is left unfinished, lead first
      held_count = n - first;
      for (k = 0; k < 3; k++) held_bytes[k] = (k < held_count) ? pend[first + k] : 8'h00;
    endfunction

    // Compare one character from the block with the oldest queued one
    function void match_char(logic [15:0] code, logic illegal, logic last_result);
      bmp_char_t want_char;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got code %h illegal %b last %b",
                 $time, code, illegal, last_result);
        mismatch_count++;
        return;
      end
      want_char = pending_chars.pop_front();
      if (want_char.char_code !== code) begin
        $display("%0t: char_code expected %h, got %h", $time, want_char.char_code, code);
        mismatch_count++;
      end
      if (want_char.illegal !== illegal) begin
        $display("%0t: illegal expected %b, got %b", $time, want_char.illegal, illegal);
        mismatch_count++;
      end
      if (want_char.last_result !== last_result) begin
        $display("%0t: last_result expected %b, got %b", $time, want_char.last_result,
                 last_result);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_char_code;
  logic        out_illegal;
  logic        out_last_result;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 60;
  int unsigned cycle_count = 0;
  int unsigned sent_bytes = 0;

  utf8_char_tracker tracker = new();

  // Ranges, illegal leads, a 4-character flush and a string ending mid-sequence
  logic [7:0] opening_bytes [25] = '{
    8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80,
    8'h41, 8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF5, 8'hFF, 8'hC1, 8'hF4, 8'h8F,
    8'hBF, 8'hBF, 8'hE2, 8'h82, 8'h80
  };

  utf8_to_bmp_decoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_illegal     (out_illegal),
    .out_last_result (out_last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.take_byte(in_data_byte, in_end_of_string);
    if (rst_n && out_valid && !out_stall)
      tracker.match_char(out_char_code, out_illegal, out_last_result);
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  // Legal second byte for a lead, honoring the narrowed ranges
  function automatic logic [7:0] second_byte(logic [7:0] lead);
    case (lead)
      8'hE0:   return 8'($urandom_range(8'hA0, 8'hBF));
      8'hED:   return 8'($urandom_range(8'h80, 8'h9F));
      8'hF0:   return 8'($urandom_range(8'h90, 8'hBF));
      8'hF4:   return 8'($urandom_range(8'h80, 8'h8F));
      default: return 8'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  // Send one sequence: mostly well formed, sometimes corrupted, cut or pure noise
  task automatic send_random_run();
    logic [7:0]  run_bytes [$];
    logic [7:0]  lead;
    int unsigned span;
    int unsigned k;
    if ($urandom_range(0, 9) == 0) begin
      run_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      span = $urandom_range(1, 4);
      case (span)
        1:       lead = 8'($urandom_range(8'h00, 8'h7F));
        2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
        3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
        default: lead = 8'($urandom_range(8'hF0, 8'hF4));
      endcase
      run_bytes.push_back(lead);
      for (k = 1; k < span; k++)
        run_bytes.push_back((k == 1) ? second_byte(lead) : 8'($urandom_range(8'h80, 8'hBF)));
      if (span > 1 && $urandom_range(0, 5) == 0)
        run_bytes[$urandom_range(1, span - 1)] = 8'($urandom_range(0, 255));
      if (span > 1 && $urandom_range(0, 7) == 0)
        void'(run_bytes.pop_back());
    end
    foreach (run_bytes[j])
      send_item(run_bytes[j], $urandom_range(0, 11) == 0);
  endtask

  // Hold the sender until every queued character has come back
  task automatic drain_chars();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = sent_bytes + PHASE_ITEMS;
    while (sent_bytes < stop_at) send_random_run();
    drain_chars();
  endtask

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_bytes[k])
      send_item(opening_bytes[k], k == 23 || k == 24);
    drain_chars();

    run_phase(9, 60);
    run_phase(60, 9);
    run_phase(0, 0);

    // settle, then look for stray characters
    repeat (20) @(posedge clk);
    if (tracker.pending_count() != 0)
      $display("%0t: %0d characters never arrived", $time, tracker.pending_count());
    if (tracker.mismatch_count == 0 && tracker.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
